FILE: rtl/adib_pkg.sv
// Shared types and constants for the adaptive depth interval binner.
// Holds the register codes, reset values, field widths and the
// controller-to-datapath command and status structures. No dependencies.
package adib_pkg;

  // Field widths.
  localparam int DEPTH_W     = 24;  // Q8.16 depths and lengths
  localparam int SLOPE_W     = 18;  // Q2.16 slope
  localparam int CUR_W       = 25;  // Cumulative depth, one bit of headroom
  localparam int FRAC_W      = 16;  // Fraction bits of the growth product
  localparam int PROD_W      = 44;  // Product plus rounding carry
  localparam int GROW_W      = PROD_W - FRAC_W;
  localparam int INDEX_W     = 7;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  // Rounding constant: one half in the product's fraction.
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // Saturated upper bound.
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // Default interval cap.
  localparam int MAX_INTERVALS_DEF = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADAPTIVE_MODE = 3'd0,
    REG_MIN_LENGTH    = 3'd1,
    REG_MAX_LENGTH    = 3'd2,
    REG_SLOPE_FACTOR  = 3'd3,
    REG_DEPTH_LIMIT   = 3'd4
  } cfg_reg_t;

  // Register reset values.
  localparam logic                 ADAPTIVE_MODE_RST = 1'b1;
  localparam logic [DEPTH_W-1:0]   MIN_LENGTH_RST    = 24'd6554;
  localparam logic [DEPTH_W-1:0]   MAX_LENGTH_RST    = 24'd65536;
  localparam logic [SLOPE_W-1:0]   SLOPE_FACTOR_RST  = 18'd32768;
  localparam logic [DEPTH_W-1:0]   DEPTH_LIMIT_RST   = 24'd655360;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // Load the query and clear the generator
    logic mul;       // Register the rounded growth product
    logic step;      // Advance the cumulative depth by one interval
    logic fin_hit;   // Capture the interval that holds the query
    logic fin_oor;   // Capture the out-of-range result
    logic load_out;  // Move the captured result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cond_ok;   // Generation may continue
    logic hit;       // The new upper bound reaches the query
  } status_t;

endpackage

FILE: rtl/adib_ctrl.sv
// Controller for the adaptive depth interval binner.
// Sequences one query through alternating multiply and step cycles and
// hands the result to the output register. Depends on adib_pkg.
module adib_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  adib_pkg::status_t status,
  output adib_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    MUL,
    STEP,
    PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output slot is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = MUL;
        end
      end
      MUL: begin
        if (status.cond_ok) begin
          cmd.mul    = 1'b1;
          state_next = STEP;
        end else begin
          cmd.fin_oor = 1'b1;
          state_next  = PUSH;
        end
      end
      STEP: begin
        cmd.step = 1'b1;
        if (status.hit) begin
          cmd.fin_hit = 1'b1;
          state_next  = PUSH;
        end else begin
          state_next = MUL;
        end
      end
      PUSH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/adib_dp.sv
// Datapath for the adaptive depth interval binner.
// Holds the configuration registers, the interval generator with its
// multiplier, the result capture and the output register. Depends on adib_pkg.
module adib_dp #(
  parameter int MAX_INTERVALS = adib_pkg::MAX_INTERVALS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [adib_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [adib_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [adib_pkg::DEPTH_W-1:0]        query_depth,
  input  adib_pkg::cmd_t                      cmd,
  output adib_pkg::status_t                   status,
  output logic [adib_pkg::INDEX_W-1:0]        interval_index,
  output logic [adib_pkg::DEPTH_W-1:0]        lower_bound,
  output logic [adib_pkg::DEPTH_W-1:0]        upper_bound,
  output logic [adib_pkg::DEPTH_W-1:0]        interval_length,
  output logic                                out_of_range
);

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_INTERVALS);

  // Configuration registers.
  logic                           adaptive_mode;
  logic [adib_pkg::DEPTH_W-1:0]   min_length;
  logic [adib_pkg::DEPTH_W-1:0]   max_length;
  logic [adib_pkg::SLOPE_W-1:0]   slope_factor;
  logic [adib_pkg::DEPTH_W-1:0]   depth_limit;

  // Generator state.
  logic [adib_pkg::DEPTH_W-1:0]   query;
  logic [adib_pkg::CUR_W-1:0]     cur;
  logic [CNT_W-1:0]               count;
  logic                           first;
  logic                           capped;
  logic [adib_pkg::PROD_W-1:0]    prod;

  // Captured result.
  logic [adib_pkg::INDEX_W-1:0]   res_index;
  logic [adib_pkg::DEPTH_W-1:0]   res_lower;
  logic [adib_pkg::DEPTH_W-1:0]   res_upper;
  logic [adib_pkg::DEPTH_W-1:0]   res_len;
  logic                           res_oor;

  // Combinational terms.
  logic [adib_pkg::PROD_W-1:0]    prod_next;
  logic [adib_pkg::GROW_W-1:0]    grow;
  logic                           grow_over;
  logic                           grow_under;
  logic [adib_pkg::DEPTH_W-1:0]   len;
  logic [adib_pkg::CUR_W-1:0]     cur_sum;
  logic [CNT_W+adib_pkg::INDEX_W-1:0] count_wide;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_mode <= adib_pkg::ADAPTIVE_MODE_RST;
      min_length    <= adib_pkg::MIN_LENGTH_RST;
      max_length    <= adib_pkg::MAX_LENGTH_RST;
      slope_factor  <= adib_pkg::SLOPE_FACTOR_RST;
      depth_limit   <= adib_pkg::DEPTH_LIMIT_RST;
    end else if (cfg_write) begin
      case (adib_pkg::cfg_reg_t'(cfg_index))
        adib_pkg::REG_ADAPTIVE_MODE: adaptive_mode <= cfg_data[0];
        adib_pkg::REG_MIN_LENGTH:    min_length    <= cfg_data[adib_pkg::DEPTH_W-1:0];
        adib_pkg::REG_MAX_LENGTH:    max_length    <= cfg_data[adib_pkg::DEPTH_W-1:0];
        adib_pkg::REG_SLOPE_FACTOR:  slope_factor  <= cfg_data[adib_pkg::SLOPE_W-1:0];
        adib_pkg::REG_DEPTH_LIMIT:   depth_limit   <= cfg_data[adib_pkg::DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Growth product with the rounding half folded in as an addend.
  assign prod_next = {{(adib_pkg::PROD_W-adib_pkg::SLOPE_W){1'b0}}, slope_factor}
                   * {{(adib_pkg::PROD_W-adib_pkg::CUR_W){1'b0}}, cur}
                   + adib_pkg::ROUND_HALF;
  assign grow = prod[adib_pkg::PROD_W-1:adib_pkg::FRAC_W];

  // Clamp: the max test wins over the min test.
  assign grow_over  = grow > {{(adib_pkg::GROW_W-adib_pkg::DEPTH_W){1'b0}}, max_length};
  assign grow_under = grow < {{(adib_pkg::GROW_W-adib_pkg::DEPTH_W){1'b0}}, min_length};

  always_comb begin
    if (first) begin
      len = min_length;
    end else if (capped || grow_over) begin
      len = max_length;
    end else if (grow_under) begin
      len = min_length;
    end else begin
      len = grow[adib_pkg::DEPTH_W-1:0];
    end
  end

  // Next upper bound and the loop tests.
  assign cur_sum        = cur + {1'b0, len};
  assign status.hit     = cur_sum >= {1'b0, query};
  assign status.cond_ok = (cur < {1'b0, depth_limit}) && (count < CNT_LIMIT);
  assign count_wide     = {{adib_pkg::INDEX_W{1'b0}}, count};

  // Interval generator.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query  <= query_depth;
      cur    <= '0;
      count  <= '0;
      first  <= adaptive_mode;
      capped <= !adaptive_mode;
    end else if (cmd.step) begin
      cur    <= cur_sum;
      count  <= count + CNT_W'(1);
      first  <= 1'b0;
      capped <= capped || (!first && grow_over);
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
  end

  // Result capture, for the holding interval or for a query past the end.
  always_ff @(posedge clk) begin
    if (cmd.fin_hit) begin
      res_index <= count_wide[adib_pkg::INDEX_W-1:0];
      res_lower <= cur[adib_pkg::DEPTH_W-1:0];
      res_upper <= cur_sum[adib_pkg::CUR_W-1] ? adib_pkg::DEPTH_MAX
                                                : cur_sum[adib_pkg::DEPTH_W-1:0];
      res_len   <= len;
      res_oor   <= 1'b0;
    end else if (cmd.fin_oor) begin
      res_index <= count_wide[adib_pkg::INDEX_W-1:0];
      res_lower <= '0;
      res_upper <= '0;
      res_len   <= max_length;
      res_oor   <= 1'b1;
    end
  end

  // Output register, loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      interval_index  <= res_index;
      lower_bound     <= res_lower;
      upper_bound     <= res_upper;
      interval_length <= res_len;
      out_of_range    <= res_oor;
    end
  end

endmodule

FILE: rtl/adaptive_depth_interval_binner.sv
// Adaptive depth interval binner: one query in, one interval result out.
// Each interval passes the MUL state on the 18x25 growth multiplier, then the
// STEP state for the clamp and add; a query is out of range after n intervals
// (n <= MAX_INTERVALS) without a hit. One query is processed at a time; a
// finished result waits in the output register. Reset is synchronous and
// restores the configuration registers and the controller state.
module adaptive_depth_interval_binner #(
  parameter int MAX_INTERVALS = adib_pkg::MAX_INTERVALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [adib_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [adib_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [adib_pkg::DEPTH_W-1:0]      query_depth,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [adib_pkg::INDEX_W-1:0]      interval_index,
  output logic [adib_pkg::DEPTH_W-1:0]      lower_bound,
  output logic [adib_pkg::DEPTH_W-1:0]      upper_bound,
  output logic [adib_pkg::DEPTH_W-1:0]      interval_length,
  output logic                              out_of_range
);

  adib_pkg::cmd_t    cmd;
  adib_pkg::status_t status;

  // Sequencer.
  adib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Configuration, generator and output register.
  adib_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .query_depth     (query_depth),
    .cmd             (cmd),
    .status          (status),
    .interval_index  (interval_index),
    .lower_bound     (lower_bound),
    .upper_bound     (upper_bound),
    .interval_length (interval_length),
    .out_of_range    (out_of_range)
  );

endmodule

FILE: rtl/adib_checker.sv
// Port-level checks for the adaptive depth interval binner.
// Watches the top level's ports only and is attached by the bind below.
// Depends on adib_pkg.
module adib_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [adib_pkg::INDEX_W-1:0]      interval_index,
  input logic [adib_pkg::DEPTH_W-1:0]      lower_bound,
  input logic [adib_pkg::DEPTH_W-1:0]      upper_bound,
  input logic [adib_pkg::DEPTH_W-1:0]      interval_length,
  input logic                              out_of_range
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(interval_index)
      && $stable(lower_bound) && $stable(upper_bound)
      && $stable(interval_length) && $stable(out_of_range))
    else $error("stalled result changed");

  // Only one query is in work: acceptance closes the input until it finishes.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second query accepted while busy");

  // A query past the last interval reports zero bounds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> lower_bound == '0 && upper_bound == '0)
    else $error("out-of-range result has nonzero bounds");

  // An interval never ends below its start.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> upper_bound >= lower_bound)
    else $error("interval upper bound below lower bound");

endmodule

bind adaptive_depth_interval_binner adib_checker u_adib_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .interval_index  (interval_index),
  .lower_bound     (lower_bound),
  .upper_bound     (upper_bound),
  .interval_length (interval_length),
  .out_of_range    (out_of_range)
);

FILE: tb/adib_interval_checker.sv
// Checker for the adaptive depth interval binner: watches the configuration
// port and both channels, predicts each interval result and compares it.
// Depends on adib_pkg for widths, register codes and reset values.
`timescale 1ns / 1ps

module adib_interval_checker
  import adib_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [DEPTH_W-1:0]     query_depth,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [INDEX_W-1:0]     interval_index,
  input  logic [DEPTH_W-1:0]     lower_bound,
  input  logic [DEPTH_W-1:0]     upper_bound,
  input  logic [DEPTH_W-1:0]     interval_length,
  input  logic                   out_of_range,
  output int                     fail_count,
  output int                     pending
);

  // One predicted interval result.
  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [DEPTH_W-1:0] lower;
    logic [DEPTH_W-1:0] upper;
    logic [DEPTH_W-1:0] length;
    logic               oor;
  } bin_result_t;

  // Shadow copy of the configuration registers.
  logic               mode_q;
  logic [DEPTH_W-1:0] min_q;
  logic [DEPTH_W-1:0] max_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [DEPTH_W-1:0] limit_q;

  bin_result_t bins_due[$];

  // Walk the intervals from zero until one reaches the query.
  function automatic bin_result_t predict_bin(input logic [DEPTH_W-1:0] q);
    bin_result_t        r;
    logic [CUR_W-1:0]   cur;
    logic [DEPTH_W-1:0] len;
    logic [PROD_W-1:0]  grow;
    int                 count;
    logic               first;
    logic               capped;
    logic               found;
    cur    = '0;
    count  = 0;
    first  = mode_q;
    capped = !mode_q;
    found  = 1'b0;
    r.index  = '0;
    r.lower  = '0;
    r.upper  = '0;
    r.length = max_q;
    r.oor    = 1'b1;
    while (!found && cur < CUR_W'(limit_q) && count < MAX_INTERVALS) begin
      if (first) begin
        len   = min_q;
        first = 1'b0;
      end else if (capped) begin
        len = max_q;
      end else begin
        // The max clamp is tested first and latches for the rest of the walk.
        grow = (PROD_W'(slope_q) * PROD_W'(cur) + ROUND_HALF) >> FRAC_W;
        if (grow > PROD_W'(max_q)) begin
          len    = max_q;
          capped = 1'b1;
        end else if (grow < PROD_W'(min_q)) begin
          len = min_q;
        end else begin
          len = DEPTH_W'(grow);
        end
      end
      cur = cur + CUR_W'(len);
      if (cur >= CUR_W'(q)) begin
        found    = 1'b1;
        r.index  = INDEX_W'(count);
        r.lower  = DEPTH_W'(cur - CUR_W'(len));
        r.upper  = (cur > CUR_W'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(cur);
        r.length = len;
        r.oor    = 1'b0;
      end else begin
        count++;
      end
    end
    if (!found) begin
      r.index = INDEX_W'(count);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Track configuration, queue predictions, and compare each result transaction.
  always @(posedge clk) begin
    if (rst) begin
      mode_q  <= ADAPTIVE_MODE_RST;
      min_q   <= MIN_LENGTH_RST;
      max_q   <= MAX_LENGTH_RST;
      slope_q <= SLOPE_FACTOR_RST;
      limit_q <= DEPTH_LIMIT_RST;
      bins_due.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ADAPTIVE_MODE: mode_q  <= cfg_data[0];
          REG_MIN_LENGTH:    min_q   <= cfg_data;
          REG_MAX_LENGTH:    max_q   <= cfg_data;
          REG_SLOPE_FACTOR:  slope_q <= cfg_data[SLOPE_W-1:0];
          REG_DEPTH_LIMIT:   limit_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        bins_due = {bins_due, predict_bin(query_depth)};
      end
      if (out_valid && !out_stall) begin
        if (bins_due.size() == 0) begin
          $error("result transaction with no query outstanding");
          fail_count++;
        end else begin
          bin_result_t e;
          e = bins_due.pop_front();
          check_field("interval_index", 32'(e.index), 32'(interval_index));
          check_field("lower_bound", 32'(e.lower), 32'(lower_bound));
          check_field("upper_bound", 32'(e.upper), 32'(upper_bound));
          check_field("interval_length", 32'(e.length), 32'(interval_length));
          check_field("out_of_range", 32'(e.oor), 32'(out_of_range));
        end
      end
      pending = bins_due.size();
    end
  end

endmodule

FILE: tb/tb_adaptive_depth_interval_binner.sv
// Top of the binner testbench: clock, reset, configuration phases and query
// stimulus with random idling. Depends on adib_pkg, the binner and
// adib_interval_checker, which predicts and compares the results.
`timescale 1ns / 1ps

module tb_adaptive_depth_interval_binner;
  import adib_pkg::*;

  localparam int MAX_BINS       = MAX_INTERVALS_DEF;
  localparam int REG_COUNT      = 5;
  localparam int FIXED_SETTINGS = 10;
  localparam int RANDOM_SETTINGS = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 2 * MAX_BINS + 8;

  // One full register setting; mode and slope carry raw 24-bit write data.
  typedef struct {
    logic [CFG_DATA_W-1:0] mode_raw;
    logic [CFG_DATA_W-1:0] min_len;
    logic [CFG_DATA_W-1:0] max_len;
    logic [CFG_DATA_W-1:0] slope_raw;
    logic [CFG_DATA_W-1:0] limit;
  } binner_cfg_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [DEPTH_W-1:0]     query_depth;
  logic                   out_valid;
  logic                   out_stall;
  logic [INDEX_W-1:0]     interval_index;
  logic [DEPTH_W-1:0]     lower_bound;
  logic [DEPTH_W-1:0]     upper_bound;
  logic [DEPTH_W-1:0]     interval_length;
  logic                   out_of_range;

  int          fail_count;
  int          pending;
  int          in_idle_pct;
  int          out_stall_pct;
  int          quiet_cycles;
  binner_cfg_t active_cfg;

  adaptive_depth_interval_binner #(.MAX_INTERVALS(MAX_BINS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .query_depth(query_depth),
    .out_valid(out_valid), .out_stall(out_stall),
    .interval_index(interval_index), .lower_bound(lower_bound),
    .upper_bound(upper_bound), .interval_length(interval_length),
    .out_of_range(out_of_range)
  );

  adib_interval_checker #(.MAX_INTERVALS(MAX_BINS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .query_depth(query_depth),
    .out_valid(out_valid), .out_stall(out_stall),
    .interval_index(interval_index), .lower_bound(lower_bound),
    .upper_bound(upper_bound), .interval_length(interval_length),
    .out_of_range(out_of_range),
    .fail_count(fail_count), .pending(pending)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The receiver stalls at random at the configured rate.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Watchdog: too many cycles without any transaction or register write.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Settings that cover the extremes and each special case.
  function automatic binner_cfg_t fixed_setting(input int k);
    binner_cfg_t c;
    case (k)
      0: c = '{24'd1, 24'd6554, 24'd65536, 24'd32768, 24'd655360};
      // Non-adaptive: every interval is max_length.
      1: c = '{24'd0, 24'd6554, 24'd65536, 24'd32768, 24'd655360};
      // All ones, upper bound saturation and masking of mode and slope.
      2: c = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      3: c = '{24'hFFFFFE, 24'd1, 24'd1, 24'hFC0000, 24'd1};
      // Minimum above maximum, so the max clamp wins.
      4: c = '{24'd1, 24'd100000, 24'd5000, 24'd65536, 24'd2000000};
      // Short intervals against a far limit, so the interval cap ends the walk.
      5: c = '{24'd1, 24'd1000, 24'd20000, 24'd100, 24'hFFFFFF};
      // Zero lengths give empty intervals until the cap.
      6: c = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd1000};
      7: c = '{24'd1, 24'd3000, 24'd70000, 24'd0, 24'd500000};
      8: c = '{24'd1, 24'd2000, 24'd1000000, 24'h03FFFF, 24'd16000000};
      default: c = '{24'd0, 24'd500, 24'd1, 24'd1, 24'hFFFFFF};
    endcase
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_length();
    if ($urandom_range(2) != 0) begin
      return CFG_DATA_W'($urandom_range(1, 100000));
    end
    return CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
  endfunction

  function automatic binner_cfg_t random_setting();
    binner_cfg_t c;
    c.mode_raw  = CFG_DATA_W'($urandom) | CFG_DATA_W'($urandom_range(3) != 0);
    c.min_len   = random_length();
    c.max_len   = random_length();
    c.slope_raw = CFG_DATA_W'($urandom);
    c.limit     = CFG_DATA_W'($urandom_range(1, 4000000));
    return c;
  endfunction

  // Queries mostly fall inside the generated span, the rest anywhere.
  function automatic logic [DEPTH_W-1:0] random_query();
    int unsigned span;
    int unsigned pick;
    span = active_cfg.limit + active_cfg.max_len;
    if (span > 32'hFFFFFF) begin
      span = 32'hFFFFFF;
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      return DEPTH_W'($urandom_range(0, span));
    end else if (pick < 75) begin
      return DEPTH_W'($urandom);
    end else if (pick < 85) begin
      return DEPTH_W'($urandom_range(0, 2 * active_cfg.min_len));
    end else if (pick < 90) begin
      return '0;
    end else if (pick < 95) begin
      return DEPTH_MAX;
    end
    return active_cfg.limit - DEPTH_W'($urandom_range(1));
  endfunction

  task automatic set_idling(input int m);
    case (m)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 45; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 45; end
      default: begin in_idle_pct = 38; out_stall_pct = 38; end
    endcase
  endtask

  // Offer one query transaction, with random idle cycles ahead of it.
  task automatic send_query(input logic [DEPTH_W-1:0] q);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    query_depth <= q;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Wait until every query has its result, then load a new setting.
  task automatic apply_setting(input binner_cfg_t c);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    write_reg(REG_ADAPTIVE_MODE, c.mode_raw);
    write_reg(REG_MIN_LENGTH, c.min_len);
    write_reg(REG_MAX_LENGTH, c.max_len);
    write_reg(REG_SLOPE_FACTOR, c.slope_raw);
    write_reg(REG_DEPTH_LIMIT, c.limit);
    // Writes to unused indexes must leave the registers alone.
    write_reg(CFG_INDEX_W'(REG_COUNT + $urandom_range(2)), CFG_DATA_W'($urandom));
    cfg_write  <= 1'b0;
    active_cfg = c;
    @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    query_depth   = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    active_cfg    = fixed_setting(0);
    // Hold reset, then release it on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed queries on the reset setting, around the first bounds and extremes.
    send_query(24'd0);
    send_query(24'd1);
    send_query(24'd6553);
    send_query(24'd6554);
    send_query(24'd6555);
    send_query(24'd655359);
    send_query(24'd655360);
    send_query(24'd655361);
    send_query(24'h800000);
    send_query(DEPTH_MAX);

    // Minimum above maximum.
    apply_setting(fixed_setting(4));
    send_query(24'd0);
    send_query(24'd5000);
    send_query(24'd100000);
    send_query(24'd105001);
    send_query(24'd2000000);

    // Interval cap and out of range.
    apply_setting(fixed_setting(5));
    send_query(24'd1);
    send_query(DEPTH_MAX);

    // Zero lengths.
    apply_setting(fixed_setting(6));
    send_query(24'd0);
    send_query(24'd1);

    // All-ones registers with a saturated upper bound.
    apply_setting(fixed_setting(2));
    send_query(24'd0);
    send_query(24'd1);
    send_query(DEPTH_MAX);

    // Random phases over fixed and random settings and all idling patterns.
    for (int p = 0; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++) begin
      apply_setting((p < FIXED_SETTINGS) ? fixed_setting(p) : random_setting());
      set_idling(p % 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_query(random_query());
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/adib_pkg.sv
rtl/adib_ctrl.sv
rtl/adib_dp.sv
rtl/adaptive_depth_interval_binner.sv
rtl/adib_checker.sv
tb/adib_interval_checker.sv
tb/tb_adaptive_depth_interval_binner.sv
